// ===== design/box_section_mesh_extruder_macros.svh =====
// Assertion macros shared by the box-section mesh extruder RTL.
`ifndef BOX_SECTION_MESH_EXTRUDER_MACROS_SVH
`define BOX_SECTION_MESH_EXTRUDER_MACROS_SVH

// Check cons in the same cycle as ante; expects clk and rst_n in scope.
`define BSME_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante; expects clk and rst_n in scope.
`define BSME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bsme_pkg.sv =====
// Shared types, constants and arithmetic helpers of the box-section mesh extruder.
package bsme_pkg;

    localparam int IDX_W = 32;

    typedef enum logic
    {
        KIND_VERTEX = 1'b0,
        KIND_TRI    = 1'b1
    } kind_t;

    localparam logic REG_EDGE_EN   = 1'b0;
    localparam logic REG_EDGE_RGBA = 1'b1;

    typedef struct packed
    {
        logic        edge_en;
        logic [31:0] edge_rgba;
    } cfg_t;

    typedef struct packed
    {
        logic [2:0][31:0] ctr;
        logic [2:0][32:0] p1;
        logic [2:0][32:0] p2;
        logic [2:0][15:0] a1;
        logic [2:0][15:0] a2;
        logic [31:0]      color;
        logic             tri_en;
        logic [IDX_W-1:0] base;
    } item_t;

    typedef struct packed
    {
        kind_t            kind;
        logic [2:0][31:0] pos;
        logic [2:0][15:0] norm;
        logic [31:0]      color;
        logic [2:0][31:0] tri_idx;
        logic             last;
    } rec_t;

    // Corner j takes -a1*h1 at corners 0,5,6,7 and -a2*h2 at corners 3,4,5,6.
    function automatic logic corner_neg1(input logic [2:0] j);
        return (j == 3'd0) || (j == 3'd5) || (j == 3'd6) || (j == 3'd7);
    endfunction

    function automatic logic corner_neg2(input logic [2:0] j);
        return (j == 3'd3) || (j == 3'd4) || (j == 3'd5) || (j == 3'd6);
    endfunction

    // Negate if asked, then round Q10.22 to Q16.16, half up.
    function automatic logic signed [27:0] round_term(input logic signed [32:0] p,
                                                      input logic neg);
        logic signed [33:0] q;
        logic signed [33:0] b;
        q = neg ? -(34'(p)) : 34'(p);
        b = q + 34'sd32;
        return b[33:6];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [33:0] s);
        logic [31:0] r;
        if ((s[33:31] == 3'b000) || (s[33:31] == 3'b111))
            r = s[31:0];
        else if (s[33])
            r = 32'h8000_0000;
        else
            r = 32'h7FFF_FFFF;
        return r;
    endfunction

    function automatic logic [15:0] norm_sel(input logic [15:0] v, input logic neg);
        logic [15:0] r;
        if (!neg)
            r = v;
        else if (v == 16'h8000)
            r = 16'h7FFF;
        else
            r = -v;
        return r;
    endfunction

endpackage

// ===== design/bsme_cfg.sv =====
// APB register file holding the edge color settings.
module bsme_cfg
    import bsme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic        edge_en_reg;
    logic [31:0] edge_rgba_reg;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_en_reg   <= 1'b0;
            edge_rgba_reg <= 32'd0;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_EDGE_EN)
                edge_en_reg <= pwdata[0];
            else
                edge_rgba_reg <= pwdata;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_EDGE_EN:   prdata = {31'd0, edge_en_reg};
            REG_EDGE_RGBA: prdata = edge_rgba_reg;
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.edge_en   = edge_en_reg;
    assign cfg.edge_rgba = edge_rgba_reg;

endmodule

// ===== design/bsme_rec.sv =====
// Record builder: one vertex or triangle record from the held point and its record number.
module bsme_rec
    import bsme_pkg::*;
(
    input  item_t      item,
    input  logic [3:0] rec_cnt,
    input  cfg_t       cfg,
    output rec_t       rec
);

    logic [2:0]        j;
    logic              is_tri;
    logic              neg1;
    logic              neg2;
    logic signed [27:0] t1 [3];
    logic signed [27:0] t2 [3];
    logic signed [33:0] sum [3];
    logic [IDX_W-1:0]  cur;
    logic [IDX_W-1:0]  prev;
    logic [IDX_W-1:0]  m;

    assign j      = rec_cnt[2:0];
    assign is_tri = rec_cnt[3];
    assign neg1   = corner_neg1(j);
    assign neg2   = corner_neg2(j);
    assign cur    = item.base;
    assign prev   = item.base - IDX_W'(8);
    assign m      = IDX_W'({j[2:1], 1'b0});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t1[k]  = round_term($signed(item.p1[k]), neg1);
            t2[k]  = round_term($signed(item.p2[k]), neg2);
            sum[k] = 34'($signed(item.ctr[k])) + 34'(t1[k]) + 34'(t2[k]);
        end
    end

    always_comb
    begin
        rec      = '0;
        rec.last = (j == 3'd7) && (is_tri || !item.tri_en);
        if (is_tri)
        begin
            rec.kind = KIND_TRI;
            if (!j[0])
            begin
                rec.tri_idx[0] = 32'(prev + m);
                rec.tri_idx[1] = 32'(prev + m + IDX_W'(1));
                rec.tri_idx[2] = 32'(cur + m);
            end
            else
            begin
                rec.tri_idx[0] = 32'(prev + m + IDX_W'(1));
                rec.tri_idx[1] = 32'(cur + m + IDX_W'(1));
                rec.tri_idx[2] = 32'(cur + m);
            end
        end
        else
        begin
            rec.kind = KIND_VERTEX;
            for (int k = 0; k < 3; k++)
            begin
                rec.pos[k]  = sat32(sum[k]);
                rec.norm[k] = norm_sel(j[1] ? item.a1[k] : item.a2[k], j[2]);
            end
            rec.color = (cfg.edge_en && j[1]) ? cfg.edge_rgba : item.color;
        end
    end

endmodule

// ===== design/box_section_mesh_extruder.sv =====
// Top level of the box-section mesh extruder: point register, record sequencer, result register.
//
// Usage:
//   s_axis carries one section point per beat; m_axis carries vertex and triangle records.
//   Each point yields eight vertex records (corners 0..7), then, when a previous point
//   exists and the point's tuser (tube start) is low, eight triangle records joining the
//   previous section to this one. tlast marks the final record of a point.
//   The APB port sets the edge color enable (address 0) and edge color (address 4).
// Flow: a taken beat goes to the point register, then its first record to the result register.
// Throughput: one record per cycle on m_axis while m_axis_tready stays high; the result
//   channel sets the pace, since a stall there stops the record sequencer. The next
//   point is taken in the cycle its predecessor's last record enters the result register.
// Reset: vertex numbering restarts at zero, no previous section is held, both color
//   registers clear and no record is pending.
// Stall: while a record is pending and m_axis_tready is low, the result register holds it and the
//   sequencer stops; s_axis_tready stays low until the last record can move.
module box_section_mesh_extruder
    import bsme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_x, center_y, center_z, axis_one_x/y/z, axis_two_x/y/z, half_widths, point_color
    input  logic [255:0] s_axis_tdata,
    // tube_start
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x, pos_y, pos_z, norm_x/y/z, color_out, tri_index_a, tri_index_b, tri_index_c
    output logic [271:0] m_axis_tdata,
    // item_kind
    output logic         m_axis_tuser,
    // last_of_point
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    `include "box_section_mesh_extruder_macros.svh"

    cfg_t             cfg;
    item_t            item_reg;
    item_t            item_next;
    rec_t             rec;
    rec_t             out_reg;
    logic             out_valid_reg;
    logic             busy_reg;
    logic [3:0]       rec_cnt_reg;
    logic [IDX_W-1:0] vertex_base_reg;
    logic             have_prev_reg;
    logic             out_free;
    logic             adv;
    logic             adv_last;
    logic             in_acc;
    logic [15:0]      h1;
    logic [15:0]      h2;

    bsme_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bsme_rec u_rec
    (
        .item    (item_reg),
        .rec_cnt (rec_cnt_reg),
        .cfg     (cfg),
        .rec     (rec)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign adv           = busy_reg && out_free;
    assign adv_last      = adv && rec.last;
    assign s_axis_tready = !busy_reg || adv_last;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign h1 = s_axis_tdata[207:192];
    assign h2 = s_axis_tdata[223:208];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            item_next.ctr[k] = s_axis_tdata[32*k +: 32];
            item_next.a1[k]  = s_axis_tdata[96 + 16*k +: 16];
            item_next.a2[k]  = s_axis_tdata[144 + 16*k +: 16];
            item_next.p1[k]  = 33'($signed(s_axis_tdata[96 + 16*k +: 16])
                                   * $signed({1'b0, h1}));
            item_next.p2[k]  = 33'($signed(s_axis_tdata[144 + 16*k +: 16])
                                   * $signed({1'b0, h2}));
        end
        item_next.color  = s_axis_tdata[255:224];
        item_next.tri_en = have_prev_reg && !s_axis_tuser;
        item_next.base   = vertex_base_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            item_reg <= item_next;
        if (adv)
            out_reg <= rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            rec_cnt_reg     <= 4'd0;
            out_valid_reg   <= 1'b0;
            vertex_base_reg <= '0;
            have_prev_reg   <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                busy_reg        <= 1'b1;
                rec_cnt_reg     <= 4'd0;
                vertex_base_reg <= vertex_base_reg + IDX_W'(8);
                have_prev_reg   <= 1'b1;
            end
            else
            begin
                if (adv_last)
                    busy_reg <= 1'b0;
                if (adv)
                    rec_cnt_reg <= rec_cnt_reg + 4'd1;
            end
            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {out_reg.tri_idx[2], out_reg.tri_idx[1], out_reg.tri_idx[0],
                            out_reg.color,
                            out_reg.norm[2], out_reg.norm[1], out_reg.norm[0],
                            out_reg.pos[2], out_reg.pos[1], out_reg.pos[0]};

    `BSME_ASSERT_NEXT(a_stall_holds_count, busy_reg && !out_free,
                      $stable(rec_cnt_reg), "record count moved while result stalled")
    `BSME_ASSERT_NEXT(a_accept_starts, in_acc,
                      busy_reg && (rec_cnt_reg == 4'd0), "point taken without restart")
    `BSME_ASSERT_SAME(a_tri_only_joined, busy_reg && rec_cnt_reg[3],
                      item_reg.tri_en, "triangle record for an unjoined point")
    `BSME_ASSERT_NEXT(a_base_step, in_acc,
                      vertex_base_reg == $past(vertex_base_reg) + IDX_W'(8),
                      "vertex base did not step by eight")

endmodule
